FILE: hw/rtl/msqrt_pkg.sv
// ---------------------------------------------------------------------------
// Modular square root package
// Shared constants, status codes and the control structs that pass between
// the sequencer and the multiply-reduce unit.
// ---------------------------------------------------------------------------
package msqrt_pkg;

  localparam int MOD_BITS_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONRES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADMOD = 2'd2;

  typedef struct packed {
    logic start;    // one-cycle pulse that launches an operation
    logic use_raw;  // reduce the raw dividend instead of the product
  } mm_req_t;

  typedef struct packed {
    logic done;     // one-cycle pulse, result is valid from then on
  } mm_rsp_t;

endpackage

FILE: hw/rtl/msqrt_mulmod.sv
// ---------------------------------------------------------------------------
// Shared multiply-reduce unit
// Computes (a * b) mod p, or raw mod p, with a multiply step followed by
// a restoring reduction that retires one dividend bit per cycle.
// ---------------------------------------------------------------------------
module msqrt_mulmod #(
  parameter int MOD_BITS = msqrt_pkg::MOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  msqrt_pkg::mm_req_t              req,
  input  logic [MOD_BITS-1:0]             op_a,
  input  logic [MOD_BITS-1:0]             op_b,
  input  logic [MOD_BITS-1:0]             p,
  input  logic [msqrt_pkg::VALUE_W-1:0]   raw,
  output msqrt_pkg::mm_rsp_t              rsp,
  output logic [MOD_BITS-1:0]             res
);

  localparam int DW = (2 * MOD_BITS > msqrt_pkg::VALUE_W) ? 2 * MOD_BITS
                                                           : msqrt_pkg::VALUE_W;
  localparam int CNT_W = $clog2(DW + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_RED  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic                  done_r, done_nxt;
  logic [DW-1:0]         dvd_r, dvd_nxt;
  logic [MOD_BITS-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [2*MOD_BITS-1:0] prod;
  logic [MOD_BITS:0]     shifted;

  assign prod    = op_a * op_b;
  assign shifted = {rem_r, dvd_r[DW-1]};

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        dvd_nxt   = req.use_raw ? DW'(raw) : DW'(prod);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DW);
        state_nxt = U_RED;
      end
      U_RED: begin
        // The remainder stays below p, so one compare-subtract per bit suffices.
        if (shifted >= {1'b0, p}) begin
          rem_nxt = MOD_BITS'(shifted - {1'b0, p});
        end else begin
          rem_nxt = MOD_BITS'(shifted);
        end
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
        end
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign res      = rem_r;

endmodule

FILE: hw/rtl/msqrt_ctrl.sv
// ---------------------------------------------------------------------------
// Modular square root sequencer
// Runs reduction, Euler's criterion, the p = 3 mod 4 shortcut and the
// Tonelli-Shanks loop as micro-steps on the shared multiply-reduce unit,
// and holds the result register of the output channel.
// ---------------------------------------------------------------------------
module msqrt_ctrl #(
  parameter int MOD_BITS = msqrt_pkg::MOD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [msqrt_pkg::VALUE_W-1:0]     in_value,
  input  logic [MOD_BITS-1:0]               in_modulus,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [MOD_BITS-1:0]               out_root,
  output logic [msqrt_pkg::STATUS_W-1:0]    out_status,
  output msqrt_pkg::mm_req_t                mm_req,
  output logic [MOD_BITS-1:0]               mm_a,
  output logic [MOD_BITS-1:0]               mm_b,
  output logic [MOD_BITS-1:0]               mm_p,
  output logic [msqrt_pkg::VALUE_W-1:0]     mm_raw,
  input  msqrt_pkg::mm_rsp_t                mm_rsp,
  input  logic [MOD_BITS-1:0]               mm_res
);

  localparam int MB   = MOD_BITS;
  localparam int CW   = $clog2(MOD_BITS + 1);
  localparam int VW   = msqrt_pkg::VALUE_W;
  localparam int SW   = msqrt_pkg::STATUS_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_RED   = 5'd2;
  localparam logic [4:0] S_EUL   = 5'd3;
  localparam logic [4:0] S_SQ3   = 5'd4;
  localparam logic [4:0] S_QS    = 5'd5;
  localparam logic [4:0] S_ZTRY  = 5'd6;
  localparam logic [4:0] S_ZCHK  = 5'd7;
  localparam logic [4:0] S_CSET  = 5'd8;
  localparam logic [4:0] S_TSET  = 5'd9;
  localparam logic [4:0] S_RSET  = 5'd10;
  localparam logic [4:0] S_LOOP  = 5'd11;
  localparam logic [4:0] S_ORD   = 5'd12;
  localparam logic [4:0] S_ORDM  = 5'd13;
  localparam logic [4:0] S_ORDE  = 5'd14;
  localparam logic [4:0] S_BSQ   = 5'd15;
  localparam logic [4:0] S_BSQM  = 5'd16;
  localparam logic [4:0] S_CUPD  = 5'd17;
  localparam logic [4:0] S_TUPD  = 5'd18;
  localparam logic [4:0] S_RUPD  = 5'd19;
  localparam logic [4:0] S_PLOOP = 5'd20;
  localparam logic [4:0] S_PACC  = 5'd21;
  localparam logic [4:0] S_PSQ   = 5'd22;
  localparam logic [4:0] S_PBASE = 5'd23;
  localparam logic [4:0] S_MWAIT = 5'd24;
  localparam logic [4:0] S_FIN   = 5'd25;

  logic [4:0]    state_r, state_nxt;
  logic [4:0]    mul_ret_r, mul_ret_nxt;
  logic [4:0]    pw_ret_r, pw_ret_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [MB-1:0] p_r, p_nxt;
  logic [MB-1:0] n_r, n_nxt;
  logic [MB-1:0] q_r, q_nxt;
  logic [MB-1:0] z_r, z_nxt;
  logic [MB-1:0] c_r, c_nxt;
  logic [MB-1:0] t_r, t_nxt;
  logic [MB-1:0] r_r, r_nxt;
  logic [MB-1:0] sq_r, sq_nxt;
  logic [MB-1:0] b_r, b_nxt;
  logic [MB-1:0] acc_r, acc_nxt;
  logic [MB-1:0] base_r, base_nxt;
  logic [MB-1:0] e_r, e_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [MB-1:0] mm_a_r, mm_a_nxt;
  logic [MB-1:0] mm_b_r, mm_b_nxt;
  logic          mm_start_r, mm_start_nxt;
  logic          mm_raw_sel_r, mm_raw_sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [MB-1:0] out_root_r, out_root_nxt;
  logic [SW-1:0] out_status_r, out_status_nxt;
  logic [MB-1:0] res_root_r, res_root_nxt;
  logic [SW-1:0] res_status_r, res_status_nxt;

  // Sub-call requests, applied after the main case.
  logic          call_mul, call_raw, call_pw, fin_req;
  logic [MB-1:0] call_a, call_b, pw_base, pw_exp, fin_root;
  logic [4:0]    call_ret, pw_ret;
  logic [SW-1:0] fin_status;

  logic [VW-1:0] mag;
  logic [MB-1:0] red_n;
  logic [MB-1:0] half_pm1;
  logic [MB:0]   p_inc;
  logic [MB-1:0] q_inc;
  logic [CW:0]   ji_sum;

  assign mag      = v_r[VW-1] ? (~v_r + VW'(1)) : v_r;
  assign red_n    = (v_r[VW-1] && (mm_res != '0)) ? (p_r - mm_res) : mm_res;
  assign half_pm1 = (p_r - MB'(1)) >> 1;
  assign p_inc    = {1'b0, p_r} + (MB+1)'(1);
  assign q_inc    = q_r + MB'(1);
  assign ji_sum   = {1'b0, j_r} + {1'b0, i_r} + (CW+1)'(1);

  always_comb begin
    state_nxt      = state_r;
    mul_ret_nxt    = mul_ret_r;
    pw_ret_nxt     = pw_ret_r;
    v_nxt          = v_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    q_nxt          = q_r;
    z_nxt          = z_r;
    c_nxt          = c_r;
    t_nxt          = t_r;
    r_nxt          = r_r;
    sq_nxt         = sq_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    e_nxt          = e_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    m_nxt          = m_r;
    mm_a_nxt       = mm_a_r;
    mm_b_nxt       = mm_b_r;
    mm_start_nxt   = 1'b0;
    mm_raw_sel_nxt = mm_raw_sel_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_root_nxt   = out_root_r;
    out_status_nxt = out_status_r;
    res_root_nxt   = res_root_r;
    res_status_nxt = res_status_r;

    call_mul   = 1'b0;
    call_raw   = 1'b0;
    call_a     = '0;
    call_b     = '0;
    call_ret   = S_IDLE;
    call_pw    = 1'b0;
    pw_base    = '0;
    pw_exp     = '0;
    pw_ret     = S_IDLE;
    fin_req    = 1'b0;
    fin_root   = '0;
    fin_status = msqrt_pkg::ST_FOUND;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt     = in_value;
          p_nxt     = in_modulus;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (p_r < MB'(2)) begin
          fin_req    = 1'b1;
          fin_status = msqrt_pkg::ST_BADMOD;
        end else begin
          call_mul = 1'b1;
          call_raw = 1'b1;
          call_ret = S_RED;
        end
      end
      S_RED: begin
        if (red_n == '0) begin
          fin_req = 1'b1;
        end else if (p_r == MB'(2)) begin
          fin_req  = 1'b1;
          fin_root = red_n;
        end else begin
          n_nxt   = red_n;
          call_pw = 1'b1;
          pw_base = red_n;
          pw_exp  = half_pm1;
          pw_ret  = S_EUL;
        end
      end
      S_EUL: begin
        if (acc_r != MB'(1)) begin
          fin_req    = 1'b1;
          fin_status = msqrt_pkg::ST_NONRES;
        end else if (p_r[1:0] == 2'b11) begin
          call_pw = 1'b1;
          pw_base = n_r;
          pw_exp  = MB'(p_inc >> 2);
          pw_ret  = S_SQ3;
        end else begin
          q_nxt     = p_r - MB'(1);
          m_nxt     = '0;
          state_nxt = S_QS;
        end
      end
      S_SQ3: begin
        fin_req  = 1'b1;
        fin_root = acc_r;
      end
      S_QS: begin
        // p is at least three here, so q never reaches zero.
        if (!q_r[0]) begin
          q_nxt = q_r >> 1;
          m_nxt = m_r + CW'(1);
        end else begin
          z_nxt     = MB'(2);
          state_nxt = S_ZTRY;
        end
      end
      S_ZTRY: begin
        if (z_r >= p_r) begin
          fin_req    = 1'b1;
          fin_status = msqrt_pkg::ST_BADMOD;
        end else begin
          call_pw = 1'b1;
          pw_base = z_r;
          pw_exp  = half_pm1;
          pw_ret  = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (acc_r == (p_r - MB'(1))) begin
          call_pw = 1'b1;
          pw_base = z_r;
          pw_exp  = q_r;
          pw_ret  = S_CSET;
        end else begin
          z_nxt     = z_r + MB'(1);
          state_nxt = S_ZTRY;
        end
      end
      S_CSET: begin
        c_nxt   = acc_r;
        call_pw = 1'b1;
        pw_base = n_r;
        pw_exp  = q_r;
        pw_ret  = S_TSET;
      end
      S_TSET: begin
        t_nxt   = acc_r;
        call_pw = 1'b1;
        pw_base = n_r;
        pw_exp  = q_inc >> 1;
        pw_ret  = S_RSET;
      end
      S_RSET: begin
        r_nxt     = acc_r;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (t_r == MB'(1)) begin
          fin_req  = 1'b1;
          fin_root = r_r;
        end else begin
          i_nxt     = '0;
          sq_nxt    = t_r;
          b_nxt     = c_r;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        if (sq_r == MB'(1)) begin
          state_nxt = S_ORDE;
        end else if (i_r >= m_r) begin
          fin_req    = 1'b1;
          fin_status = msqrt_pkg::ST_BADMOD;
        end else begin
          call_mul = 1'b1;
          call_a   = sq_r;
          call_b   = sq_r;
          call_ret = S_ORDM;
        end
      end
      S_ORDM: begin
        sq_nxt    = mm_res;
        i_nxt     = i_r + CW'(1);
        state_nxt = S_ORD;
      end
      S_ORDE: begin
        if (i_r >= m_r) begin
          fin_req    = 1'b1;
          fin_status = msqrt_pkg::ST_BADMOD;
        end else begin
          j_nxt     = '0;
          state_nxt = S_BSQ;
        end
      end
      S_BSQ: begin
        call_mul = 1'b1;
        call_a   = b_r;
        call_b   = b_r;
        if (ji_sum < {1'b0, m_r}) begin
          call_ret = S_BSQM;
        end else begin
          m_nxt    = i_r;
          call_ret = S_CUPD;
        end
      end
      S_BSQM: begin
        b_nxt     = mm_res;
        j_nxt     = j_r + CW'(1);
        state_nxt = S_BSQ;
      end
      S_CUPD: begin
        c_nxt    = mm_res;
        call_mul = 1'b1;
        call_a   = t_r;
        call_b   = mm_res;
        call_ret = S_TUPD;
      end
      S_TUPD: begin
        t_nxt    = mm_res;
        call_mul = 1'b1;
        call_a   = r_r;
        call_b   = b_r;
        call_ret = S_RUPD;
      end
      S_RUPD: begin
        r_nxt     = mm_res;
        state_nxt = S_LOOP;
      end
      S_PLOOP: begin
        if (e_r == '0) begin
          state_nxt = pw_ret_r;
        end else if (e_r[0]) begin
          call_mul = 1'b1;
          call_a   = acc_r;
          call_b   = base_r;
          call_ret = S_PACC;
        end else begin
          state_nxt = S_PSQ;
        end
      end
      S_PACC: begin
        acc_nxt   = mm_res;
        state_nxt = S_PSQ;
      end
      S_PSQ: begin
        // The final squaring of the base is never used, so it is skipped.
        if ((e_r >> 1) == '0) begin
          e_nxt     = '0;
          state_nxt = S_PLOOP;
        end else begin
          call_mul = 1'b1;
          call_a   = base_r;
          call_b   = base_r;
          call_ret = S_PBASE;
        end
      end
      S_PBASE: begin
        base_nxt  = mm_res;
        e_nxt     = e_r >> 1;
        state_nxt = S_PLOOP;
      end
      S_MWAIT: begin
        if (mm_rsp.done) begin
          state_nxt = mul_ret_r;
        end
      end
      S_FIN: begin
        // The finished result waits here until the previous one has left.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = res_root_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (call_mul) begin
      mm_a_nxt       = call_a;
      mm_b_nxt       = call_b;
      mm_raw_sel_nxt = call_raw;
      mm_start_nxt   = 1'b1;
      mul_ret_nxt    = call_ret;
      state_nxt      = S_MWAIT;
    end
    if (call_pw) begin
      acc_nxt    = MB'(1);
      base_nxt   = pw_base;
      e_nxt      = pw_exp;
      pw_ret_nxt = pw_ret;
      state_nxt  = S_PLOOP;
    end
    if (fin_req) begin
      res_root_nxt   = (fin_status == msqrt_pkg::ST_FOUND) ? fin_root : '0;
      res_status_nxt = fin_status;
      state_nxt      = S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mm_start_r  <= mm_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_ret_r    <= mul_ret_nxt;
    pw_ret_r     <= pw_ret_nxt;
    v_r          <= v_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    q_r          <= q_nxt;
    z_r          <= z_nxt;
    c_r          <= c_nxt;
    t_r          <= t_nxt;
    r_r          <= r_nxt;
    sq_r         <= sq_nxt;
    b_r          <= b_nxt;
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    e_r          <= e_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    m_r          <= m_nxt;
    mm_a_r       <= mm_a_nxt;
    mm_b_r       <= mm_b_nxt;
    mm_raw_sel_r <= mm_raw_sel_nxt;
    out_root_r   <= out_root_nxt;
    out_status_r <= out_status_nxt;
    res_root_r   <= res_root_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_root       = out_root_r;
  assign out_status     = out_status_r;
  assign mm_req.start   = mm_start_r;
  assign mm_req.use_raw = mm_raw_sel_r;
  assign mm_a           = mm_a_r;
  assign mm_b           = mm_b_r;
  assign mm_p           = p_r;
  assign mm_raw         = mag;

endmodule

FILE: hw/rtl/modular_square_root_core.sv
// Each multiply-reduce runs the bit-per-cycle reduction in the shared unit; a power takes
// up to 2*MOD_BITS of them. An item with a modulus below two ends without a multiply; else it
// takes one multiply, which ends a zero residue or p = 2, then a power for Euler's criterion
// and one for p = 3 mod 4; Tonelli-Shanks adds a power per non-residue candidate, three more
// and up to s*(s+2) multiplies in its loop.
// One item at a time; in_tready is high only while idle. Reset: synchronous rst_n.
// ---------------------------------------------------------------------------
// Modular square root core
// Reduces a signed value modulo a prime and returns its square root using
// Euler's criterion and Tonelli-Shanks, with a status for non-residues and
// for moduli that make the procedure fail.
// ---------------------------------------------------------------------------
module modular_square_root_core #(
  parameter int MOD_BITS = msqrt_pkg::MOD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // value [31:0], modulus [MOD_BITS+31:32], zero padding above
  input  logic [((msqrt_pkg::VALUE_W+MOD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // root [MOD_BITS-1:0], zero padding above
  output logic [((MOD_BITS+7)/8)*8-1:0]                out_tdata,
  // status [1:0]
  output logic [msqrt_pkg::STATUS_W-1:0]               out_tuser
);

  localparam int VW     = msqrt_pkg::VALUE_W;
  localparam int OUT_DW = ((MOD_BITS + 7) / 8) * 8;

  msqrt_pkg::mm_req_t  mm_req;
  msqrt_pkg::mm_rsp_t  mm_rsp;
  logic [MOD_BITS-1:0] mm_a, mm_b, mm_p, mm_res;
  logic [VW-1:0]       mm_raw;
  logic [MOD_BITS-1:0] root;

  msqrt_ctrl #(
    .MOD_BITS (MOD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata[VW-1:0]),
    .in_modulus (in_tdata[VW+MOD_BITS-1:VW]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_root   (root),
    .out_status (out_tuser),
    .mm_req     (mm_req),
    .mm_a       (mm_a),
    .mm_b       (mm_b),
    .mm_p       (mm_p),
    .mm_raw     (mm_raw),
    .mm_rsp     (mm_rsp),
    .mm_res     (mm_res)
  );

  msqrt_mulmod #(
    .MOD_BITS (MOD_BITS)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .op_a  (mm_a),
    .op_b  (mm_b),
    .p     (mm_p),
    .raw   (mm_raw),
    .rsp   (mm_rsp),
    .res   (mm_res)
  );

  assign out_tdata = OUT_DW'(root);

endmodule
